@@ design/pnno_pkg.sv @@
// Shared types, codes and constants of the palette nearest-neighbour ordering block.
package pnno_pkg;

  localparam int MAX_COLORS_DEF = 256;
  localparam int DIST_W = 18;

  typedef logic [23:0] color_t;
  typedef logic [DIST_W-1:0] dist_t;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_REMAP = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_LOADED = 2'd0,
    ST_ANSWER = 2'd1,
    ST_ERROR  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PAIR,
    S_PDRAIN,
    S_PL0,
    S_PL1,
    S_SCAN,
    S_SDRAIN,
    S_PLN,
    S_RD1,
    S_RD2,
    S_RD3,
    S_MP1,
    S_MP2
  } state_t;

endpackage

@@ design/pnno_dist.sv @@
// Registered squared colour distance unit shared by all searches of the ordering.
module pnno_dist #(
  parameter int TAG_W = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  pnno_pkg::color_t   col_a,
  input  pnno_pkg::color_t   col_b,
  input  logic [TAG_W-1:0]   in_tag,
  output logic               dist_vld,
  output pnno_pkg::dist_t    dsq,
  output logic [TAG_W-1:0]   dist_tag
);
  import pnno_pkg::*;

  logic [7:0]  ad_r, ad_g, ad_b;
  logic [15:0] sq_r, sq_g, sq_b;
  logic        vld_r;
  dist_t       dist_r;
  logic [TAG_W-1:0] tag_r;

  always_comb begin
    ad_r = (col_a[23:16] > col_b[23:16]) ? col_a[23:16] - col_b[23:16]
                                         : col_b[23:16] - col_a[23:16];
    ad_g = (col_a[15:8] > col_b[15:8]) ? col_a[15:8] - col_b[15:8]
                                       : col_b[15:8] - col_a[15:8];
    ad_b = (col_a[7:0] > col_b[7:0]) ? col_a[7:0] - col_b[7:0]
                                     : col_b[7:0] - col_a[7:0];
    sq_r = ad_r * ad_r;
    sq_g = ad_g * ad_g;
    sq_b = ad_b * ad_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    dist_r <= DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);
    tag_r  <= in_tag;
  end

  assign dist_vld = vld_r;
  assign dsq      = dist_r;
  assign dist_tag = tag_r;

endmodule

@@ design/palette_nearest_neighbor_order.sv @@
// Top level of the palette nearest-neighbour ordering block: sequencer and stores.
// Usage: colours are loaded one beat at a time on the in_ channel with action load;
// the beat with in_last_color set starts the ordering of the loaded palette unless the store was full.
// Read beats return the ordered entry at a position; remap beats return the new
// position of an old palette index. Every input beat gives exactly one out_ beat.
// A load gives its result in the cycle after acceptance; a valid read steps through
// S_RD1 to S_RD3 and a valid remap through S_MP1 and S_MP2 before the result is
// registered. The block takes one beat at a time: in_ready is low while a beat is
// in work and while a result waits in the output register. Ordering of n colours
// runs through one registered distance unit fed by two read ports of the colour
// store, at most one distance per cycle: all pairs are compared for the closest
// pair, then the last placed colour with each unused one per further position.
// When the receiver stalls, the result holds in the output register and no
// new beat is taken until it is delivered.
// Reset clears the colour count, the ordered flag and the used marks; the
// stores themselves are not cleared and need no clearing pass.
module palette_nearest_neighbor_order #(
  parameter int MAX_COLORS = pnno_pkg::MAX_COLORS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_action,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  logic       in_last_color,
  input  logic [7:0] in_position,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic [7:0] out_original_index,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [8:0] out_new_index
);
  import pnno_pkg::*;

  localparam int AW = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
  localparam int CW = $clog2(MAX_COLORS + 1);

  state_t state_r, state_nxt;

  color_t          col_mem [MAX_COLORS];
  logic [AW-1:0]   ord_mem [MAX_COLORS];
  logic [AW-1:0]   inv_mem [MAX_COLORS];
  logic [MAX_COLORS-1:0] used_r;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ordered_r;
  logic [CW-1:0] ii_r, jj_r, pos_r;
  logic [AW-1:0] last_r, best_i_r, best_j_r;
  dist_t         best_r;
  logic          have_r;
  logic [7:0]    q_pos_r;

  color_t        ca_q_r, cb_q_r;
  logic [AW-1:0] ord_q_r, inv_q_r;
  logic          s1_vld_r;
  logic [2*AW-1:0] s1_tag_r;

  logic          dist_vld;
  dist_t         dsq;
  logic [2*AW-1:0] dist_tag;

  logic          in_acc, out_vld_r;
  logic [1:0]    out_st_r;
  logic [7:0]    out_oi_r, out_r_r, out_g_r, out_b_r;
  logic [8:0]    out_ni_r;

  logic [CW-1:0] eff_cnt;
  logic          load_ok, pos_in;
  logic          iss_vld;
  logic [AW-1:0] addr_a, addr_b;
  logic          res_go;
  logic [1:0]    res_st;
  logic [7:0]    res_oi, res_r, res_g, res_b;
  logic [8:0]    res_ni;
  logic          plc_en;
  logic [AW-1:0] plc_pos, plc_idx;
  logic          drained;

  assign in_acc  = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE) && !out_vld_r;
  assign eff_cnt = ordered_r ? '0 : cnt_r;
  assign load_ok = eff_cnt < CW'(MAX_COLORS);
  assign pos_in  = {1'b0, in_position} < 9'(cnt_r);
  assign drained = !s1_vld_r && !dist_vld;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (action_t'(in_action))
            ACT_LOAD: begin
              if (load_ok && in_last_color) begin
                state_nxt = (eff_cnt == '0) ? S_PL0 : S_PAIR;
              end
            end
            ACT_READ: begin
              if (ordered_r && pos_in) state_nxt = S_RD1;
            end
            ACT_REMAP: begin
              if (ordered_r && pos_in) state_nxt = S_MP1;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_PAIR: begin
        if (jj_r == cnt_r - CW'(1) && ii_r == cnt_r - CW'(2)) state_nxt = S_PDRAIN;
      end
      S_PDRAIN: if (drained) state_nxt = S_PL0;
      S_PL0:    state_nxt = (cnt_r == CW'(1)) ? S_IDLE : S_PL1;
      S_PL1:    state_nxt = (cnt_r == CW'(2)) ? S_IDLE : S_SCAN;
      S_SCAN:   if (jj_r == cnt_r - CW'(1)) state_nxt = S_SDRAIN;
      S_SDRAIN: if (drained) state_nxt = S_PLN;
      S_PLN:    state_nxt = (pos_r + CW'(1) == cnt_r) ? S_IDLE : S_SCAN;
      S_RD1:    state_nxt = S_RD2;
      S_RD2:    state_nxt = S_RD3;
      S_RD3:    state_nxt = S_IDLE;
      S_MP1:    state_nxt = S_MP2;
      S_MP2:    state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    iss_vld = 1'b0;
    addr_a  = ii_r[AW-1:0];
    addr_b  = jj_r[AW-1:0];
    res_go  = 1'b0;
    res_st  = ST_ERROR;
    res_oi  = '0;
    res_r   = '0;
    res_g   = '0;
    res_b   = '0;
    res_ni  = '0;
    plc_en  = 1'b0;
    plc_pos = '0;
    plc_idx = best_i_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (action_t'(in_action))
            ACT_LOAD: begin
              res_go = 1'b1;
              res_st = load_ok ? ST_LOADED : ST_ERROR;
            end
            ACT_READ: begin
              res_go = !(ordered_r && pos_in);
            end
            ACT_REMAP: begin
              res_go = !(ordered_r && pos_in);
              if (ordered_r) begin
                res_st = ST_ANSWER;
                res_ni = 9'(cnt_r);
              end
            end
            default: res_go = 1'b1;
          endcase
        end
      end
      S_PAIR: iss_vld = 1'b1;
      S_SCAN: begin
        addr_a  = last_r;
        iss_vld = !used_r[jj_r[AW-1:0]];
      end
      S_PL0: plc_en = 1'b1;
      S_PL1: begin
        plc_en  = 1'b1;
        plc_pos = AW'(1);
        plc_idx = best_j_r;
      end
      S_PLN: begin
        plc_en  = 1'b1;
        plc_pos = pos_r[AW-1:0];
        plc_idx = best_j_r;
      end
      S_RD2: addr_a = ord_q_r;
      S_RD3: begin
        res_go = 1'b1;
        res_st = ST_ANSWER;
        res_oi = 8'(ord_q_r);
        res_r  = ca_q_r[23:16];
        res_g  = ca_q_r[15:8];
        res_b  = ca_q_r[7:0];
      end
      S_MP2: begin
        res_go = 1'b1;
        res_st = ST_ANSWER;
        res_ni = 9'(inv_q_r);
      end
      default: iss_vld = 1'b0;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc && action_t'(in_action) == ACT_LOAD) begin
      cnt_nxt = load_ok ? eff_cnt + CW'(1) : eff_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      ordered_r <= 1'b0;
      used_r    <= '0;
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      have_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      s1_vld_r <= iss_vld;
      if (in_acc && action_t'(in_action) == ACT_LOAD) begin
        ordered_r <= 1'b0;
        if (load_ok && in_last_color) begin
          used_r <= '0;
          have_r <= 1'b0;
        end
      end
      if (plc_en) used_r[plc_idx] <= 1'b1;
      if ((state_r == S_PL0 && state_nxt == S_IDLE) ||
          (state_r == S_PL1 && state_nxt == S_IDLE) ||
          (state_r == S_PLN && state_nxt == S_IDLE)) begin
        ordered_r <= 1'b1;
      end
      if (state_r == S_PL1 || state_r == S_PLN) begin
        have_r <= 1'b0;
      end else if (dist_vld && (!have_r || dsq < best_r)) begin
        have_r <= 1'b1;
      end
      if (res_go) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Iterators, search results and output payload.
  always_ff @(posedge clk) begin
    if (in_acc) q_pos_r <= in_position;
    if (in_acc && action_t'(in_action) == ACT_LOAD) begin
      ii_r     <= '0;
      jj_r     <= CW'(1);
      best_i_r <= '0;
    end
    if (state_r == S_PAIR) begin
      if (jj_r == cnt_r - CW'(1)) begin
        ii_r <= ii_r + CW'(1);
        jj_r <= ii_r + CW'(2);
      end else begin
        jj_r <= jj_r + CW'(1);
      end
    end
    if (state_r == S_SCAN) jj_r <= jj_r + CW'(1);
    if (state_r == S_PL1) begin
      last_r <= best_j_r;
      pos_r  <= CW'(2);
      jj_r   <= '0;
    end
    if (state_r == S_PLN) begin
      last_r <= best_j_r;
      pos_r  <= pos_r + CW'(1);
      jj_r   <= '0;
    end
    if (dist_vld && (!have_r || dsq < best_r) && state_r != S_PL1 && state_r != S_PLN) begin
      best_r   <= dsq;
      best_i_r <= dist_tag[2*AW-1:AW];
      best_j_r <= dist_tag[AW-1:0];
    end
    if (res_go) begin
      out_st_r <= res_st;
      out_oi_r <= res_oi;
      out_r_r  <= res_r;
      out_g_r  <= res_g;
      out_b_r  <= res_b;
      out_ni_r <= res_ni;
    end
  end

  // Stores.
  always_ff @(posedge clk) begin
    if (in_acc && action_t'(in_action) == ACT_LOAD && load_ok) begin
      col_mem[eff_cnt[AW-1:0]] <= {in_red, in_green, in_blue};
    end
    ca_q_r   <= col_mem[addr_a];
    cb_q_r   <= col_mem[addr_b];
    s1_tag_r <= {addr_a, addr_b};
  end

  always_ff @(posedge clk) begin
    if (plc_en) ord_mem[plc_pos] <= plc_idx;
    ord_q_r <= ord_mem[q_pos_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (plc_en) inv_mem[plc_idx] <= plc_pos;
    inv_q_r <= inv_mem[q_pos_r[AW-1:0]];
  end

  pnno_dist #(
    .TAG_W(2*AW)
  ) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s1_vld_r),
    .col_a    (ca_q_r),
    .col_b    (cb_q_r),
    .in_tag   (s1_tag_r),
    .dist_vld (dist_vld),
    .dsq      (dsq),
    .dist_tag (dist_tag)
  );

  assign out_valid          = out_vld_r;
  assign out_status         = out_st_r;
  assign out_original_index = out_oi_r;
  assign out_red            = out_r_r;
  assign out_green          = out_g_r;
  assign out_blue           = out_b_r;
  assign out_new_index      = out_ni_r;

  a_no_flag_while_ordering: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PAIR || state_r == S_SCAN) |-> !ordered_r)
    else $error("ordered flag set during ordering");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_COLORS))
    else $error("colour count beyond capacity");

  a_dist_only_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    dist_vld |-> (state_r == S_PAIR || state_r == S_PDRAIN ||
                  state_r == S_SCAN || state_r == S_SDRAIN))
    else $error("distance result outside a search");

  a_used_matches_pos: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PLN |-> $countones(used_r) == int'(pos_r))
    else $error("used marks disagree with position");

endmodule

@@ tb/sv/palette_nearest_neighbor_order_tb.sv @@
// Testbench of the palette ordering block: directed and random beats checked against a predictor.
`timescale 1ns / 100ps

module palette_nearest_neighbor_order_tb;
  import pnno_pkg::*;

  typedef struct packed {
    status_t    status;
    logic [7:0] original_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [8:0] remap_pos;
  } answer_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] in_action;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  logic       in_last_color;
  logic [7:0] in_position;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] out_status;
  logic [7:0] out_original_index;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [8:0] out_new_index;

  palette_nearest_neighbor_order dut (.*);

  color_t     palette [256];
  logic [7:0] order_at [256];
  logic [7:0] position_of [256];
  bit         placed [256];
  int         loaded;
  bit         is_ordered;

  answer_t pending_answers [$];
  int      errors;
  int      beats_sent;
  int      send_gap_pct;
  int      recv_stall_pct;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #20_000_000;
    $display("palette_nearest_neighbor_order verification failed");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic int unsigned colour_gap(color_t a, color_t b);
    int da;
    int dg;
    int db;
    da = int'(a[23:16]) - int'(b[23:16]);
    dg = int'(a[15:8]) - int'(b[15:8]);
    db = int'(a[7:0]) - int'(b[7:0]);
    return da * da + dg * dg + db * db;
  endfunction

  task automatic put_at(int pos, int idx);
    order_at[pos] = idx[7:0];
    position_of[idx] = pos[7:0];
    placed[idx] = 1'b1;
  endtask

  task automatic sort_palette();
    int          best_i;
    int          best_j;
    int          pick;
    int unsigned best;
    int unsigned d;
    bit          found;
    for (int k = 0; k < 256; k++) placed[k] = 1'b0;
    if (loaded == 1) begin
      put_at(0, 0);
      is_ordered = 1'b1;
      return;
    end
    found = 1'b0;
    best_i = 0;
    best_j = 1;
    best = 0;
    for (int i = 0; i < loaded; i++) begin
      for (int j = i + 1; j < loaded; j++) begin
        d = colour_gap(palette[i], palette[j]);
        if (!found || d < best) begin
          found = 1'b1;
          best = d;
          best_i = i;
          best_j = j;
        end
      end
    end
    put_at(0, best_i);
    put_at(1, best_j);
    pick = best_j;
    for (int pos = 2; pos < loaded; pos++) begin
      int prev;
      prev = pick;
      found = 1'b0;
      for (int k = 0; k < loaded; k++) begin
        if (!placed[k]) begin
          d = colour_gap(palette[prev], palette[k]);
          if (!found || d < best) begin
            found = 1'b1;
            best = d;
            pick = k;
          end
        end
      end
      put_at(pos, pick);
    end
    is_ordered = 1'b1;
  endtask

  task automatic predict_answer(action_t act, color_t c, bit last, logic [7:0] pos);
    answer_t a;
    a = '0;
    a.status = ST_ERROR;
    case (act)
      ACT_LOAD: begin
        if (is_ordered) begin
          is_ordered = 1'b0;
          loaded = 0;
        end
        if (loaded < 256) begin
          palette[loaded] = c;
          loaded++;
          a.status = ST_LOADED;
          if (last) sort_palette();
        end
      end
      ACT_READ: begin
        if (is_ordered && pos < loaded) begin
          a.status = ST_ANSWER;
          a.original_index = order_at[pos];
          {a.red, a.green, a.blue} = palette[order_at[pos]];
        end
      end
      ACT_REMAP: begin
        if (is_ordered) begin
          a.status = ST_ANSWER;
          a.remap_pos = (pos < loaded) ? {1'b0, position_of[pos]} : loaded[8:0];
        end
      end
      default: ;
    endcase
    pending_answers = {pending_answers, a};
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected result beat", 1, 0);
      end else begin
        answer_t w;
        w = pending_answers.pop_front();
        if (out_status !== w.status) report_mismatch("status", out_status, w.status);
        if (out_original_index !== w.original_index)
          report_mismatch("original_index", out_original_index, w.original_index);
        if (out_red !== w.red) report_mismatch("red", out_red, w.red);
        if (out_green !== w.green) report_mismatch("green", out_green, w.green);
        if (out_blue !== w.blue) report_mismatch("blue", out_blue, w.blue);
        if (out_new_index !== w.remap_pos)
          report_mismatch("out_new_index", out_new_index, w.remap_pos);
      end
    end
  end

  task automatic send_beat(action_t act, color_t c, bit last, logic [7:0] pos);
    if (beats_sent < 550) begin
      send_gap_pct = 23;
      recv_stall_pct = 46;
    end else if (beats_sent < 1100) begin
      send_gap_pct = 46;
      recv_stall_pct = 23;
    end else begin
      send_gap_pct = 0;
      recv_stall_pct = 0;
    end
    in_valid <= 1'b1;
    in_action <= act;
    {in_red, in_green, in_blue} <= c;
    in_last_color <= last;
    in_position <= pos;
    do @(posedge clk); while (!in_ready);
    predict_answer(act, c, last, pos);
    beats_sent++;
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  function automatic color_t any_colour();
    if ($urandom_range(2) == 0) return {8'($urandom_range(3)), 8'($urandom_range(3)),
                                        8'($urandom_range(3))};
    return color_t'($urandom);
  endfunction

  task automatic test_before_ordering();
    send_beat(ACT_READ, 24'h0, 1'b0, 8'd0);
    send_beat(ACT_REMAP, 24'h0, 1'b0, 8'd0);
    send_beat(ACT_NONE, 24'hFFFFFF, 1'b1, 8'hFF);
  endtask

  task automatic test_single_colour();
    send_beat(ACT_LOAD, 24'hFFFFFF, 1'b1, 8'hFF);
    send_beat(ACT_READ, 24'h0, 1'b0, 8'd0);
    send_beat(ACT_READ, 24'h0, 1'b0, 8'd1);
    send_beat(ACT_REMAP, 24'h0, 1'b0, 8'd0);
    send_beat(ACT_REMAP, 24'h0, 1'b0, 8'd1);
    send_beat(ACT_REMAP, 24'h0, 1'b0, 8'hFF);
  endtask

  task automatic test_extremes_and_ties();
    send_beat(ACT_LOAD, 24'h000000, 1'b0, 8'd0);
    send_beat(ACT_LOAD, 24'hFFFFFF, 1'b0, 8'd0);
    send_beat(ACT_LOAD, 24'h010000, 1'b0, 8'd0);
    send_beat(ACT_LOAD, 24'h000100, 1'b0, 8'd0);
    send_beat(ACT_LOAD, 24'hFEFFFF, 1'b1, 8'd0);
    wait_results();
    for (int p = 0; p < 6; p++) begin
      send_beat(ACT_READ, 24'h0, 1'b0, p[7:0]);
      send_beat(ACT_REMAP, 24'h0, 1'b0, p[7:0]);
    end
    send_beat(ACT_NONE, 24'h0, 1'b0, 8'd2);
  endtask

  task automatic test_full_palette();
    for (int k = 0; k < 256; k++) send_beat(ACT_LOAD, color_t'($urandom), k == 255, 8'd0);
    for (int k = 0; k < 12; k++) begin
      send_beat(ACT_READ, 24'h0, 1'b0, 8'($urandom));
      send_beat(ACT_REMAP, 24'h0, 1'b0, 8'($urandom));
    end
    send_beat(ACT_READ, 24'h0, 1'b0, 8'hFF);
    send_beat(ACT_REMAP, 24'h0, 1'b0, 8'hFF);
  endtask

  task automatic test_random_palettes();
    int n;
    int queries;
    while (beats_sent < 1380) begin
      n = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 12);
      if ($urandom_range(7) == 0) begin
        send_beat(ACT_LOAD, any_colour(), 1'b0, 8'($urandom));
        send_beat(ACT_READ, 24'h0, 1'b0, 8'd0);
        send_beat(ACT_REMAP, 24'h0, 1'b0, 8'd0);
      end
      for (int k = 0; k < n; k++) send_beat(ACT_LOAD, any_colour(), k == n - 1, 8'($urandom));
      queries = $urandom_range(2, 16);
      for (int k = 0; k < queries; k++) begin
        logic [7:0] p;
        p = ($urandom_range(5) == 0) ? 8'($urandom) : 8'($urandom_range(n));
        case ($urandom_range(9))
          0: send_beat(ACT_NONE, color_t'($urandom), 1'($urandom), p);
          1, 2, 3, 4: send_beat(ACT_READ, color_t'($urandom), 1'($urandom), p);
          default: send_beat(ACT_REMAP, color_t'($urandom), 1'($urandom), p);
        endcase
      end
    end
  endtask

  task automatic test_overflow();
    for (int k = 0; k < 256; k++) send_beat(ACT_LOAD, color_t'($urandom), 1'b0, 8'd0);
    send_beat(ACT_LOAD, 24'h123456, 1'b0, 8'd0);
    send_beat(ACT_LOAD, 24'h654321, 1'b1, 8'd0);
    send_beat(ACT_READ, 24'h0, 1'b0, 8'd0);
    send_beat(ACT_REMAP, 24'h0, 1'b0, 8'd0);
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_action <= ACT_LOAD;
    in_red <= '0;
    in_green <= '0;
    in_blue <= '0;
    in_last_color <= 1'b0;
    in_position <= '0;
    errors = 0;
    beats_sent = 0;
    loaded = 0;
    is_ordered = 1'b0;
    send_gap_pct = 23;
    recv_stall_pct = 46;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_before_ordering();
    test_single_colour();
    test_extremes_and_ties();
    test_full_palette();
    test_random_palettes();
    test_overflow();

    wait_results();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("palette_nearest_neighbor_order verification clean");
    end else begin
      $display("palette_nearest_neighbor_order verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/pnno_pkg.sv
design/pnno_dist.sv
design/palette_nearest_neighbor_order.sv
tb/sv/palette_nearest_neighbor_order_tb.sv
